[rtl/iwe_pkg.sv]
`default_nettype none

package iwe_pkg;

    typedef logic [4:0] cmd_t;
    typedef logic [2:0] kind_t;
    typedef logic [2:0] group_t;
    typedef logic [1:0] status_t;

    // mnemonics in source order
    localparam cmd_t CMD_ADD  = 5'd0;
    localparam cmd_t CMD_SUB  = 5'd1;
    localparam cmd_t CMD_AND  = 5'd2;
    localparam cmd_t CMD_OR   = 5'd3;
    localparam cmd_t CMD_NOR  = 5'd4;
    localparam cmd_t CMD_MOVE = 5'd5;
    localparam cmd_t CMD_MVHI = 5'd6;
    localparam cmd_t CMD_MVLO = 5'd7;
    localparam cmd_t CMD_ADDI = 5'd8;
    localparam cmd_t CMD_SUBI = 5'd9;
    localparam cmd_t CMD_ANDI = 5'd10;
    localparam cmd_t CMD_ORI  = 5'd11;
    localparam cmd_t CMD_NORI = 5'd12;
    localparam cmd_t CMD_BNE  = 5'd13;
    localparam cmd_t CMD_BEQ  = 5'd14;
    localparam cmd_t CMD_BLT  = 5'd15;
    localparam cmd_t CMD_BGT  = 5'd16;
    localparam cmd_t CMD_LB   = 5'd17;
    localparam cmd_t CMD_SB   = 5'd18;
    localparam cmd_t CMD_LW   = 5'd19;
    localparam cmd_t CMD_SW   = 5'd20;
    localparam cmd_t CMD_LH   = 5'd21;
    localparam cmd_t CMD_SH   = 5'd22;
    localparam cmd_t CMD_JMP  = 5'd23;
    localparam cmd_t CMD_LA   = 5'd24;
    localparam cmd_t CMD_CALL = 5'd25;
    localparam cmd_t CMD_STOP = 5'd26;

    localparam kind_t KIND_ABSENT = 3'd0;
    localparam kind_t KIND_LABEL  = 3'd1;
    localparam kind_t KIND_REG    = 3'd2;
    localparam kind_t KIND_IMM    = 3'd3;
    localparam kind_t KIND_BAD    = 3'd4;

    localparam group_t GRP_R3     = 3'd0;
    localparam group_t GRP_MOVE   = 3'd1;
    localparam group_t GRP_IMM    = 3'd2;
    localparam group_t GRP_BRANCH = 3'd3;
    localparam group_t GRP_JUMP   = 3'd4;
    localparam group_t GRP_STOP   = 3'd5;
    localparam group_t GRP_NONE   = 3'd6;

    localparam status_t STATUS_OK        = 2'd0;
    localparam status_t STATUS_BAD_OPND  = 2'd1;
    localparam status_t STATUS_BAD_COUNT = 2'd2;
    localparam status_t STATUS_BAD_KIND  = 2'd3;

    localparam logic [15:0] COUNT_MAX = 16'hffff;
    localparam logic [5:0]  OP_STOP   = 6'd63;

    typedef struct packed {
        cmd_t               cmd;
        kind_t              first_kind;
        kind_t              second_kind;
        kind_t              third_kind;
        logic [4:0]         first_reg;
        logic [4:0]         second_reg;
        logic signed [15:0] immediate;
        logic [4:0]         third_reg;
    } item_t;

    typedef struct packed {
        logic [31:0] machine_word;
        logic [18:0] word_address;
        status_t     status;
    } result_t;

    function automatic group_t cmd_group(input cmd_t cmd);
        group_t g;
        unique case (cmd) inside
            [CMD_ADD:CMD_NOR]:   g = GRP_R3;
            [CMD_MOVE:CMD_MVLO]: g = GRP_MOVE;
            [CMD_ADDI:CMD_NORI]: g = GRP_IMM;
            [CMD_BNE:CMD_BGT]:   g = GRP_BRANCH;
            [CMD_LB:CMD_SH]:     g = GRP_IMM;
            [CMD_JMP:CMD_CALL]:  g = GRP_JUMP;
            CMD_STOP:            g = GRP_STOP;
            default:             g = GRP_NONE;
        endcase
        return g;
    endfunction

    function automatic logic [5:0] cmd_opcode(input cmd_t cmd);
        logic [5:0] op;
        unique case (cmd) inside
            [CMD_ADD:CMD_NOR]:   op = 6'd0;
            [CMD_MOVE:CMD_MVLO]: op = 6'd1;
            [CMD_ADDI:CMD_SH]:   op = 6'({1'b0, cmd} + 6'd2);
            CMD_JMP:             op = 6'd30;
            CMD_LA:              op = 6'd31;
            CMD_CALL:            op = 6'd32;
            CMD_STOP:            op = OP_STOP;
            default:             op = 6'd0;
        endcase
        return op;
    endfunction

    function automatic logic [4:0] cmd_funct(input cmd_t cmd);
        logic [4:0] f;
        unique case (cmd) inside
            [CMD_ADD:CMD_NOR]:   f = cmd + 5'd1;
            [CMD_MOVE:CMD_MVLO]: f = cmd - 5'd4;
            default:             f = 5'd0;
        endcase
        return f;
    endfunction

endpackage

`default_nettype wire

[rtl/iwe_encode.sv]
`default_nettype none

module iwe_encode
    import iwe_pkg::*;
(
    input  item_t       item,
    input  logic [15:0] base_address,
    input  logic [15:0] count,
    output result_t     result,
    output logic        ok
);

    group_t      grp;
    logic        p1, p2, p3;
    logic        bad_opnd, count_good, kind_good;
    logic [31:0] word;
    logic [5:0]  op;
    logic [4:0]  funct;

    assign grp   = cmd_group(item.cmd);
    assign op    = cmd_opcode(item.cmd);
    assign funct = cmd_funct(item.cmd);

    assign p1 = (item.first_kind  != KIND_ABSENT);
    assign p2 = (item.second_kind != KIND_ABSENT);
    assign p3 = (item.third_kind  != KIND_ABSENT);

    // kinds 4..7 all count as invalid
    assign bad_opnd = (item.first_kind >= KIND_BAD) || (item.second_kind >= KIND_BAD)
                   || (item.third_kind >= KIND_BAD);

    always_comb
    begin
        unique case (grp)
            GRP_STOP:                       count_good = !p1 && !p2 && !p3;
            GRP_JUMP:                       count_good = p1 && !p2 && !p3;
            GRP_MOVE:                       count_good = p1 && p2 && !p3;
            GRP_R3, GRP_IMM, GRP_BRANCH:    count_good = p1 && p2 && p3;
            default:                        count_good = 1'b0;
        endcase
    end

    always_comb
    begin
        unique case (grp)
            GRP_R3:     kind_good = (item.first_kind == KIND_REG)
                                 && (item.second_kind == KIND_REG)
                                 && (item.third_kind == KIND_REG);
            GRP_IMM:    kind_good = (item.first_kind == KIND_REG)
                                 && (item.second_kind == KIND_IMM)
                                 && (item.third_kind == KIND_REG);
            GRP_MOVE:   kind_good = (item.first_kind == KIND_REG)
                                 && (item.second_kind == KIND_REG);
            GRP_BRANCH: kind_good = (item.first_kind == KIND_REG)
                                 && (item.second_kind == KIND_REG)
                                 && (item.third_kind == KIND_LABEL);
            GRP_JUMP:   kind_good = (item.first_kind == KIND_LABEL)
                                 || (item.first_kind == KIND_REG);
            default:    kind_good = 1'b1;
        endcase
    end

    // field packing per layout, label fields stay zero
    always_comb
    begin
        word = {op, 26'd0};
        unique case (grp)
            GRP_R3:     word = word | {6'd0, item.first_reg, item.second_reg,
                                       item.third_reg, funct, 6'd0};
            GRP_MOVE:   word = word | {6'd0, item.first_reg, 5'd0,
                                       item.second_reg, funct, 6'd0};
            GRP_IMM:    word = word | {6'd0, item.first_reg, item.third_reg,
                                       item.immediate};
            GRP_BRANCH: word = word | {6'd0, item.first_reg, 21'd0};
            GRP_JUMP:
            begin
                if (item.first_kind == KIND_REG)
                    word = word | {6'd0, 1'b1, 20'd0, item.first_reg};
            end
            default:    word = word;
        endcase
    end

    always_comb
    begin
        ok = 1'b0;
        if (bad_opnd)
            result.status = STATUS_BAD_OPND;
        else if (!count_good)
            result.status = STATUS_BAD_COUNT;
        else if (!kind_good)
            result.status = STATUS_BAD_KIND;
        else
        begin
            result.status = STATUS_OK;
            ok = 1'b1;
        end
        result.machine_word = ok ? word : 32'd0;
        result.word_address = {3'd0, base_address} + {1'b0, count, 2'b00};
    end

endmodule

`default_nettype wire

[rtl/iwe_out_stage.sv]
`default_nettype none

module iwe_out_stage
    import iwe_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    load,
    input  result_t load_data,
    input  logic    out_stall,
    output logic    free,
    output logic    out_valid,
    output result_t data
);

    logic    out_valid_reg, out_valid_next;
    result_t data_reg;

    // slot frees when empty or when the current transaction leaves this cycle
    assign free = !out_valid_reg || !out_stall;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (free)
            out_valid_next = load;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (free && load)
            data_reg <= load_data;
    end

    assign out_valid = out_valid_reg;
    assign data      = data_reg;

endmodule

`default_nettype wire

[rtl/instruction_word_encoder_unit.sv]
`default_nettype none

// Instruction word encoder. Each input transaction carries one tokenised
// instruction (mnemonic, three operand kinds, register numbers, immediate)
// and produces exactly one result transaction: the 32-bit word in R, I or J
// layout, its address base_address + 4 * count, and a status (ok, invalid
// operand, wrong operand count, wrong addressing kinds, checked in that
// order). Label fields are left zero for a later linking pass. Only an ok
// instruction advances the 16-bit instruction count, which saturates at
// 0xffff; the address is reported for every status. Throughput is one
// transaction per clock while out_stall does not hold the result slot;
// each transaction passes the input register, then the result register,
// with the check and packing logic and the count update sitting between
// the two. Both sides use valid/stall: a transaction moves on an edge
// with valid high and stall low. base_address (reset 100) is written
// through cfg_we / cfg_wdata and must only change while no transaction
// is in flight.
module instruction_word_encoder_unit
    import iwe_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    // configuration
    input  logic               cfg_we,
    input  logic [15:0]        cfg_wdata,
    // input channel
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [4:0]         cmd,
    input  logic [2:0]         first_kind,
    input  logic [2:0]         second_kind,
    input  logic [2:0]         third_kind,
    input  logic [4:0]         first_reg,
    input  logic [4:0]         second_reg,
    input  logic signed [15:0] immediate,
    input  logic [4:0]         third_reg,
    // result channel
    output logic               out_valid,
    input  logic               out_stall,
    output logic [31:0]        machine_word,
    output logic [18:0]        word_address,
    output logic [1:0]         status
);

    logic [15:0] base_reg;
    logic [15:0] count_reg, count_next;
    logic        in_valid_reg, in_valid_next;
    item_t       item_reg;
    item_t       in_item;
    result_t     enc_result;
    result_t     out_data;
    logic        enc_ok;
    logic        out_free;
    logic        advance;

    // configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            base_reg <= 16'd100;
        else if (cfg_we)
            base_reg <= cfg_wdata;
    end

    assign in_item = '{cmd:         cmd,
                       first_kind:  first_kind,
                       second_kind: second_kind,
                       third_kind:  third_kind,
                       first_reg:   first_reg,
                       second_reg:  second_reg,
                       immediate:   immediate,
                       third_reg:   third_reg};

    // input register: held only while the result slot is full and stalled
    assign advance  = in_valid_reg && out_free;
    assign in_stall = in_valid_reg && !out_free;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (!in_stall)
            in_valid_next = in_valid;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else
            in_valid_reg <= in_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (!in_stall && in_valid)
            item_reg <= in_item;
    end

    // check and pack between the two registers
    iwe_encode u_encode (
        .item         (item_reg),
        .base_address (base_reg),
        .count        (count_reg),
        .result       (enc_result),
        .ok           (enc_ok)
    );

    // count moves with the transaction into the result slot, saturating
    always_comb
    begin
        count_next = count_reg;
        if (advance && enc_ok && (count_reg != COUNT_MAX))
            count_next = count_reg + 16'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else
            count_reg <= count_next;
    end

    iwe_out_stage u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (in_valid_reg),
        .load_data (enc_result),
        .out_stall (out_stall),
        .free      (out_free),
        .out_valid (out_valid),
        .data      (out_data)
    );

    assign machine_word = out_data.machine_word;
    assign word_address = out_data.word_address;
    assign status       = out_data.status;

    // rejected words are always zero
    a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (status != STATUS_OK)) |-> (machine_word == 32'd0))
        else $error("rejected transaction carries a non-zero word");

    // the count only moves when an ok transaction enters the result slot
    a_count_cause: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != $past(count_reg)) |-> $past(advance && enc_ok))
        else $error("instruction count changed without an accepted instruction");

    // saturation holds
    a_count_sat: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == COUNT_MAX) |=> (count_reg == COUNT_MAX))
        else $error("instruction count wrapped");

    // stall back to the source only when something is waiting in the input register
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (in_valid_reg && out_valid && out_stall))
        else $error("input stalled with no blocking result");

endmodule

`default_nettype wire

[bench/word_encoder_checker.sv]
`timescale 1ns / 1ps

// watches both channels of the encoder, predicts each result transaction
// and compares it field by field with what comes out
module word_encoder_checker
    import iwe_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [15:0]        cfg_wdata,
    input  logic               in_valid,
    input  logic               in_stall,
    input  logic [4:0]         cmd,
    input  logic [2:0]         first_kind,
    input  logic [2:0]         second_kind,
    input  logic [2:0]         third_kind,
    input  logic [4:0]         first_reg,
    input  logic [4:0]         second_reg,
    input  logic signed [15:0] immediate,
    input  logic [4:0]         third_reg,
    input  logic               out_valid,
    input  logic               out_stall,
    input  logic [31:0]        machine_word,
    input  logic [18:0]        word_address,
    input  logic [1:0]         status,
    output int                 mismatch_count,
    output int                 words_outstanding
);

    logic [15:0] base_addr_copy;
    logic [15:0] encoded_count;
    result_t     words_due[$];
    result_t     due_word;
    item_t       txn;

    function automatic group_t mnemonic_group(input cmd_t c);
        group_t g;
        if (c <= CMD_NOR)
            g = GRP_R3;
        else if (c <= CMD_MVLO)
            g = GRP_MOVE;
        else if (c <= CMD_NORI)
            g = GRP_IMM;
        else if (c <= CMD_BGT)
            g = GRP_BRANCH;
        else if (c <= CMD_SH)
            g = GRP_IMM;
        else if (c <= CMD_CALL)
            g = GRP_JUMP;
        else if (c == CMD_STOP)
            g = GRP_STOP;
        else
            g = GRP_NONE;
        return g;
    endfunction

    function automatic logic [5:0] mnemonic_opcode(input cmd_t c);
        logic [5:0] op;
        if (c <= CMD_NOR)
            op = 6'd0;
        else if (c <= CMD_MVLO)
            op = 6'd1;
        else if (c <= CMD_SH)
            op = {1'b0, c} + 6'd2;
        else if (c == CMD_JMP)
            op = 6'd30;
        else if (c == CMD_LA)
            op = 6'd31;
        else if (c == CMD_CALL)
            op = 6'd32;
        else
            op = OP_STOP;
        return op;
    endfunction

    function automatic result_t predict_encoding(input item_t it, input logic [15:0] base,
                                                 input logic [15:0] count);
        result_t r;
        group_t  g;
        logic    p1, p2, p3;
        logic    count_fine, kinds_fine;
        logic [4:0] funct;
        r.machine_word = 32'd0;
        r.word_address = {3'b000, base} + {1'b0, count, 2'b00};
        g  = mnemonic_group(it.cmd);
        p1 = it.first_kind != KIND_ABSENT;
        p2 = it.second_kind != KIND_ABSENT;
        p3 = it.third_kind != KIND_ABSENT;
        case (g)
            GRP_STOP: count_fine = !p1 && !p2 && !p3;
            GRP_JUMP: count_fine = p1 && !p2 && !p3;
            GRP_MOVE: count_fine = p1 && p2 && !p3;
            GRP_NONE: count_fine = 1'b0;
            default:  count_fine = p1 && p2 && p3;
        endcase
        case (g)
            GRP_R3:     kinds_fine = it.first_kind == KIND_REG && it.second_kind == KIND_REG
                                     && it.third_kind == KIND_REG;
            GRP_IMM:    kinds_fine = it.first_kind == KIND_REG && it.second_kind == KIND_IMM
                                     && it.third_kind == KIND_REG;
            GRP_MOVE:   kinds_fine = it.first_kind == KIND_REG && it.second_kind == KIND_REG;
            GRP_BRANCH: kinds_fine = it.first_kind == KIND_REG && it.second_kind == KIND_REG
                                     && it.third_kind == KIND_LABEL;
            GRP_JUMP:   kinds_fine = it.first_kind == KIND_LABEL || it.first_kind == KIND_REG;
            default:    kinds_fine = 1'b1;
        endcase
        if (it.first_kind >= KIND_BAD || it.second_kind >= KIND_BAD
            || it.third_kind >= KIND_BAD)
            r.status = STATUS_BAD_OPND;
        else if (!count_fine)
            r.status = STATUS_BAD_COUNT;
        else if (!kinds_fine)
            r.status = STATUS_BAD_KIND;
        else
        begin
            r.status       = STATUS_OK;
            r.machine_word = {mnemonic_opcode(it.cmd), 26'd0};
            case (g)
                GRP_R3:
                begin
                    funct = it.cmd - CMD_ADD + 5'd1;
                    r.machine_word |= {6'd0, it.first_reg, it.second_reg, it.third_reg,
                                       funct, 6'd0};
                end
                GRP_MOVE:
                begin
                    funct = it.cmd - CMD_MOVE + 5'd1;
                    r.machine_word |= {6'd0, it.first_reg, 5'd0, it.second_reg, funct, 6'd0};
                end
                GRP_IMM:
                    r.machine_word |= {6'd0, it.first_reg, it.third_reg, it.immediate};
                GRP_BRANCH:
                    r.machine_word |= {6'd0, it.first_reg, 21'd0};
                GRP_JUMP:
                    // register target: bit 25 set, register in the low bits
                    if (it.first_kind == KIND_REG)
                        r.machine_word |= {6'd0, 1'b1, 20'd0, it.first_reg};
                default:
                    ;
            endcase
        end
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("%0t ns: %s mismatch, got %0h expected %0h", $time, what, got, want);
        mismatch_count++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_addr_copy    = 16'd100;
            encoded_count     = 16'd0;
            words_due.delete();
            mismatch_count    = 0;
            words_outstanding = 0;
        end
        else
        begin
            if (cfg_we)
                base_addr_copy = cfg_wdata;
            if (out_valid && !out_stall)
            begin
                if (words_due.size() == 0)
                    report_mismatch("unexpected result", machine_word, 32'd0);
                else
                begin
                    due_word = words_due.pop_front();
                    if (machine_word !== due_word.machine_word)
                        report_mismatch("machine_word", machine_word, due_word.machine_word);
                    if (word_address !== due_word.word_address)
                        report_mismatch("word_address", word_address, due_word.word_address);
                    if (status !== due_word.status)
                        report_mismatch("status", status, due_word.status);
                end
            end
            if (in_valid && !in_stall)
            begin
                txn.cmd         = cmd;
                txn.first_kind  = first_kind;
                txn.second_kind = second_kind;
                txn.third_kind  = third_kind;
                txn.first_reg   = first_reg;
                txn.second_reg  = second_reg;
                txn.immediate   = immediate;
                txn.third_reg   = third_reg;
                due_word = predict_encoding(txn, base_addr_copy, encoded_count);
                words_due.push_back(due_word);
                // only a clean encode advances the count, which sticks at its top
                if (due_word.status == STATUS_OK && encoded_count != COUNT_MAX)
                    encoded_count = encoded_count + 16'd1;
            end
            words_outstanding = words_due.size();
        end
    end

endmodule

[bench/testbench.sv]
`timescale 1ns / 1ps

// stimulus and verdict for the instruction word encoder; all prediction
// and comparison lives in the checker instantiated beside the block
module testbench
    import iwe_pkg::*;
();

    // two register stages between input accept and result valid
    localparam int RESULT_LATENCY = 2;
    // cycles without any transaction on either channel before giving up
    localparam int STALL_LIMIT    = 2000;

    logic               clk         = 1'b0;
    logic               rst_n       = 1'b0;
    logic               cfg_we      = 1'b0;
    logic [15:0]        cfg_wdata   = 16'd0;
    logic               in_valid    = 1'b0;
    logic               in_stall;
    logic [4:0]         cmd         = 5'd0;
    logic [2:0]         first_kind  = 3'd0;
    logic [2:0]         second_kind = 3'd0;
    logic [2:0]         third_kind  = 3'd0;
    logic [4:0]         first_reg   = 5'd0;
    logic [4:0]         second_reg  = 5'd0;
    logic signed [15:0] immediate   = 16'sd0;
    logic [4:0]         third_reg   = 5'd0;
    logic               out_valid;
    logic               out_stall   = 1'b0;
    logic [31:0]        machine_word;
    logic [18:0]        word_address;
    logic [1:0]         status;

    int mismatch_count;
    int words_outstanding;
    int idle_cycles = 0;
    // percentages of cycles in which the sender idles and the receiver stalls
    int send_idle_pct = 35;
    int recv_stall_pct = 35;

    always #10 clk = ~clk;

    instruction_word_encoder_unit u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .cmd          (cmd),
        .first_kind   (first_kind),
        .second_kind  (second_kind),
        .third_kind   (third_kind),
        .first_reg    (first_reg),
        .second_reg   (second_reg),
        .immediate    (immediate),
        .third_reg    (third_reg),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .machine_word (machine_word),
        .word_address (word_address),
        .status       (status)
    );

    word_encoder_checker u_checker (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_we            (cfg_we),
        .cfg_wdata         (cfg_wdata),
        .in_valid          (in_valid),
        .in_stall          (in_stall),
        .cmd               (cmd),
        .first_kind        (first_kind),
        .second_kind       (second_kind),
        .third_kind        (third_kind),
        .first_reg         (first_reg),
        .second_reg        (second_reg),
        .immediate         (immediate),
        .third_reg         (third_reg),
        .out_valid         (out_valid),
        .out_stall         (out_stall),
        .machine_word      (machine_word),
        .word_address      (word_address),
        .status            (status),
        .mismatch_count    (mismatch_count),
        .words_outstanding (words_outstanding)
    );

    // receiver back-pressure, changed on the falling edge only
    always @(negedge clk)
        out_stall = $urandom_range(99) < recv_stall_pct;

    // watchdog: any transaction on either channel restarts the count
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else if (idle_cycles >= STALL_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    // an instruction whose kinds suit its mnemonic, with random registers and immediate
    function automatic item_t make_well_formed(input cmd_t op);
        item_t it;
        it.cmd        = op;
        it.first_reg  = 5'($urandom);
        it.second_reg = 5'($urandom);
        it.third_reg  = 5'($urandom);
        it.immediate  = 16'($urandom);
        if (op <= CMD_NOR)
            {it.first_kind, it.second_kind, it.third_kind} = {KIND_REG, KIND_REG, KIND_REG};
        else if (op <= CMD_MVLO)
            {it.first_kind, it.second_kind, it.third_kind} = {KIND_REG, KIND_REG, KIND_ABSENT};
        else if (op <= CMD_NORI || (op >= CMD_LB && op <= CMD_SH))
            {it.first_kind, it.second_kind, it.third_kind} = {KIND_REG, KIND_IMM, KIND_REG};
        else if (op <= CMD_BGT)
            {it.first_kind, it.second_kind, it.third_kind} = {KIND_REG, KIND_REG, KIND_LABEL};
        else if (op <= CMD_CALL)
        begin
            // jump targets are either a label or a register
            it.first_kind  = $urandom_range(1) ? KIND_LABEL : KIND_REG;
            it.second_kind = KIND_ABSENT;
            it.third_kind  = KIND_ABSENT;
        end
        else if (op == CMD_STOP)
            {it.first_kind, it.second_kind, it.third_kind} = {KIND_ABSENT, KIND_ABSENT,
                                                              KIND_ABSENT};
        else
        begin
            it.first_kind  = kind_t'($urandom);
            it.second_kind = kind_t'($urandom);
            it.third_kind  = kind_t'($urandom);
        end
        return it;
    endfunction

    // mostly well-formed instructions, some with one field broken, a few pure noise
    function automatic item_t random_instruction();
        item_t       it;
        int          pick;
        logic [63:0] noise;
        pick = $urandom_range(99);
        it   = make_well_formed(cmd_t'($urandom_range(CMD_STOP)));
        if (pick >= 88)
        begin
            noise = {$urandom, $urandom};
            it    = noise[$bits(item_t)-1:0];
        end
        else if (pick >= 75)
        begin
            case ($urandom_range(3))
                0: it.cmd         = cmd_t'($urandom_range(cmd_t'('1), CMD_STOP + 1));
                1: it.first_kind  = kind_t'($urandom);
                2: it.second_kind = kind_t'($urandom);
                default: it.third_kind = kind_t'($urandom);
            endcase
        end
        return it;
    endfunction

    // present one transaction from a falling edge and hold it until it is taken
    task automatic send_instruction(input item_t it);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        cmd         = it.cmd;
        first_kind  = it.first_kind;
        second_kind = it.second_kind;
        third_kind  = it.third_kind;
        first_reg   = it.first_reg;
        second_reg  = it.second_reg;
        immediate   = it.immediate;
        third_reg   = it.third_reg;
        in_valid    = 1'b1;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    // hold off the sender until every predicted result has come out
    task automatic drain_results();
        @(negedge clk);
        in_valid = 1'b0;
        while (words_outstanding != 0)
            @(negedge clk);
        repeat (RESULT_LATENCY + 1) @(negedge clk);
    endtask

    // base address is only changed with nothing in flight
    task automatic set_base_address(input logic [15:0] base);
        drain_results();
        cfg_wdata = base;
        cfg_we    = 1'b1;
        @(negedge clk);
        cfg_we    = 1'b0;
    endtask

    initial
    begin
        item_t probe;
        int    c;

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // every mnemonic once with the reset base, fields at alternate extremes
        for (c = CMD_ADD; c <= CMD_STOP; c++)
        begin
            probe = make_well_formed(cmd_t'(c));
            probe.first_reg  = c[0] ? 5'd31 : 5'd0;
            probe.second_reg = c[0] ? 5'd31 : 5'd0;
            probe.third_reg  = c[0] ? 5'd31 : 5'd0;
            probe.immediate  = c[0] ? 16'sh7fff : 16'sh8000;
            if (c == CMD_JMP)
                probe.first_kind = KIND_LABEL;
            if (c == CMD_LA || c == CMD_CALL)
                probe.first_kind = KIND_REG;
            send_instruction(probe);
        end

        // an invalid operand outranks a wrong operand count
        probe = make_well_formed(CMD_STOP);
        probe.first_kind = KIND_BAD;
        send_instruction(probe);
        // undefined kinds above the invalid code, one per operand slot
        probe = make_well_formed(CMD_ADD);
        probe.third_kind = kind_t'(KIND_BAD + 3);
        send_instruction(probe);
        probe.third_kind  = KIND_REG;
        probe.second_kind = kind_t'(KIND_BAD + 1);
        send_instruction(probe);
        probe.second_kind = KIND_REG;
        probe.first_kind  = kind_t'(KIND_BAD + 2);
        send_instruction(probe);
        // unknown mnemonics come back as a count error
        probe = make_well_formed(CMD_ADD);
        probe.cmd = cmd_t'(CMD_STOP + 1);
        send_instruction(probe);
        probe.cmd = cmd_t'('1);
        send_instruction(probe);
        // missing operand wins over the wrong kind of the first
        probe = make_well_formed(CMD_ADD);
        probe.first_kind = KIND_LABEL;
        probe.third_kind = KIND_ABSENT;
        send_instruction(probe);
        // wrong addressing kinds on the immediate, jump and branch forms
        probe = make_well_formed(CMD_ADDI);
        probe.second_kind = KIND_REG;
        send_instruction(probe);
        probe = make_well_formed(CMD_JMP);
        probe.first_kind = KIND_IMM;
        send_instruction(probe);
        probe = make_well_formed(CMD_BEQ);
        probe.third_kind = KIND_REG;
        send_instruction(probe);
        // a move with a third operand has one too many
        probe = make_well_formed(CMD_MOVE);
        probe.third_kind = KIND_REG;
        send_instruction(probe);

        // random phase from address zero
        set_base_address(16'd0);
        repeat (400) send_instruction(random_instruction());

        // random base, opening with a long stretch where neither side holds back
        set_base_address($urandom_range(16'hfffe, 1));
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        repeat (150) send_instruction(random_instruction());
        send_idle_pct  = 35;
        recv_stall_pct = 35;
        repeat (250) send_instruction(random_instruction());

        // top base, so the address sum reaches its widest values
        set_base_address(16'hffff);
        repeat (270) send_instruction(random_instruction());
        repeat (40) send_instruction(make_well_formed(cmd_t'($urandom_range(CMD_STOP))));

        drain_results();
        if (mismatch_count == 0 && words_outstanding == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
